// ===== sv/qti_pkg.sv =====
// qti_pkg: shared types and constants for the quadrilinear table interpolator
// no dependencies
`timescale 1ns / 1ps
package qti_pkg;
    localparam int AXIS_BITS  = 3;
    localparam int AXIS0_POINTS = 8;
    localparam int AXIS1_POINTS = 8;
    localparam int AXIS2_POINTS = 8;
    localparam int AXIS3_POINTS = 8;
    localparam int ADDR_BITS  = 4 * AXIS_BITS;
    localparam int FRAC_BITS  = 17;
    localparam int DATA_BITS  = 32;
    localparam int Q_ONE      = 65536;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_QUERY = 2'd1,
        KIND_ERROR = 2'd2,
        KIND_DROP  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t                             kind;
        logic [3:0][AXIS_BITS-1:0]         idx;
        logic [3:0][FRAC_BITS-1:0]         frac;
        logic signed [DATA_BITS-1:0]       value;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_READ  = 2'd1,
        ST_BLEND = 2'd2,
        ST_OUT   = 2'd3
    } state_t;

    function automatic logic [ADDR_BITS-1:0] flat_addr(input logic [3:0][AXIS_BITS-1:0] c);
        flat_addr = {c[0], c[1], c[2], c[3]};
    endfunction
endpackage

// ===== sv/qti_front.sv =====
// qti_front: accepts items, saturates fractions, classifies them and queues them
// depends on qti_pkg
`timescale 1ns / 1ps
module qti_front
    import qti_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    op,
    input  logic [AXIS_BITS-1:0]    upper_index_0,
    input  logic [AXIS_BITS-1:0]    upper_index_1,
    input  logic [AXIS_BITS-1:0]    upper_index_2,
    input  logic [AXIS_BITS-1:0]    upper_index_3,
    input  logic [FRAC_BITS-1:0]    fraction_0,
    input  logic [FRAC_BITS-1:0]    fraction_1,
    input  logic [FRAC_BITS-1:0]    fraction_2,
    input  logic [FRAC_BITS-1:0]    fraction_3,
    input  logic signed [DATA_BITS-1:0] entry_value,
    output logic                    cmd_valid,
    input  logic                    cmd_pop,
    output cmd_t                    cmd
);
    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
    cmd_t                  q_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]   wr_reg, rd_reg;
    logic [PTR_BITS:0]     cnt_reg;
    cmd_t                  c_in;
    logic                  push;
    logic [3:0][AXIS_BITS-1:0] ix;
    logic [3:0][FRAC_BITS-1:0] fr;
    logic [3:0]            lim;
    logic                  range_bad, zero_bad;

    assign ix = {upper_index_3, upper_index_2, upper_index_1, upper_index_0};
    assign fr = {fraction_3, fraction_2, fraction_1, fraction_0};
    assign lim[0] = 32'(ix[0]) >= AXIS0_POINTS;
    assign lim[1] = 32'(ix[1]) >= AXIS1_POINTS;
    assign lim[2] = 32'(ix[2]) >= AXIS2_POINTS;
    assign lim[3] = 32'(ix[3]) >= AXIS3_POINTS;
    assign range_bad = |lim;
    assign zero_bad = (ix[0] == '0) || (ix[1] == '0) || (ix[2] == '0) || (ix[3] == '0);

    always_comb
    begin
        c_in.idx = ix;
        c_in.value = entry_value;
        for (int k = 0; k < 4; k++)
        begin
            c_in.frac[k] = (32'(fr[k]) > Q_ONE) ? FRAC_BITS'(Q_ONE) : fr[k];
        end
        if (!op)
            c_in.kind = range_bad ? KIND_DROP : KIND_WRITE;
        else
            c_in.kind = (range_bad || zero_bad) ? KIND_ERROR : KIND_QUERY;
    end

    assign in_stall = (cnt_reg == (PTR_BITS+1)'(QUEUE_DEPTH));
    assign push = in_valid && !in_stall;
    assign cmd_valid = (cnt_reg != '0);
    assign cmd = q_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_reg] <= c_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (cmd_pop)
                rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (PTR_BITS+1)'(push) - (PTR_BITS+1)'(cmd_pop);
        end
    end
endmodule

// ===== sv/qti_back.sv =====
// qti_back: table memory, corner reads and shared blend unit
// depends on qti_pkg
`timescale 1ns / 1ps
module qti_back
    import qti_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cmd_valid,
    output logic                    cmd_pop,
    input  cmd_t                    cmd,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [DATA_BITS-1:0] interpolated,
    output logic                    index_error
);
    localparam int DEPTH = 1 << ADDR_BITS;
    logic signed [DATA_BITS-1:0] mem [DEPTH];
    logic signed [DATA_BITS-1:0] rdata_reg;

    state_t state_reg, state_next;
    logic [4:0] rcnt_reg, rcnt_next;       // read issue count
    logic       rvalid_reg;
    logic [3:0] rcorner_reg;
    logic signed [15:0][DATA_BITS-1:0] v_reg;
    logic [3:0] bcnt_reg, bcnt_next;       // blend step 0..14
    cmd_t       cur_reg;
    logic [3:0][AXIS_BITS-1:0] p;
    logic       mem_we, mem_re;
    logic signed [DATA_BITS-1:0] res_reg;
    logic       err_reg;
    logic       ov_reg;

    // blend datapath
    logic [1:0] axis;
    logic [3:0] src, dst;
    logic signed [DATA_BITS-1:0] a, b;
    logic signed [DATA_BITS+1:0] d;
    logic signed [DATA_BITS+FRAC_BITS+2:0] prod, s;
    logic signed [DATA_BITS-1:0] blended;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
            p[k] = rcnt_reg[k] ? cur_reg.idx[k] : cur_reg.idx[k] - 1'b1;
    end

    assign mem_we = (state_reg == ST_IDLE) && cmd_valid && (cmd.kind == KIND_WRITE);
    assign mem_re = (state_reg == ST_READ) && (rcnt_reg < 5'd16);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[flat_addr(cmd.idx)] <= cmd.value;
        if (mem_re)
            rdata_reg <= mem[flat_addr(p)];
    end

    // step order: 8 blends on axis 0, 4 on axis 1, 2 on axis 2, 1 on axis 3
    always_comb
    begin
        if (bcnt_reg < 4'd8)
        begin
            axis = 2'd0; dst = bcnt_reg;
        end
        else if (bcnt_reg < 4'd12)
        begin
            axis = 2'd1; dst = bcnt_reg - 4'd8;
        end
        else if (bcnt_reg < 4'd14)
        begin
            axis = 2'd2; dst = bcnt_reg - 4'd12;
        end
        else
        begin
            axis = 2'd3; dst = 4'd0;
        end
        src = {dst[2:0], 1'b0};
        a = v_reg[src];
        b = v_reg[src + 4'd1];
        d = (DATA_BITS+2)'(b) - (DATA_BITS+2)'(a);
        prod = (DATA_BITS+FRAC_BITS+3)'(d) * $signed({1'b0, cur_reg.frac[axis]});
        s = prod + ((DATA_BITS+FRAC_BITS+3)'(a) <<< 16) + (DATA_BITS+FRAC_BITS+3)'(32768);
        blended = DATA_BITS'(s >>> 16);
    end

    always_comb
    begin
        state_next = state_reg;
        rcnt_next = rcnt_reg;
        bcnt_next = bcnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                rcnt_next = '0;
                bcnt_next = '0;
                if (cmd_valid)
                begin
                    unique case (cmd.kind)
                        KIND_QUERY: state_next = ST_READ;
                        KIND_ERROR: state_next = ST_OUT;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_READ:
            begin
                if (rcnt_reg < 5'd16)
                    rcnt_next = rcnt_reg + 5'd1;
                if (rvalid_reg && rcorner_reg == 4'd15)
                    state_next = ST_BLEND;
            end
            ST_BLEND:
            begin
                bcnt_next = bcnt_reg + 4'd1;
                if (bcnt_reg == 4'd14)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!ov_reg)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_pop = (state_reg == ST_IDLE) && cmd_valid;
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
            cur_reg <= cmd;
        rcorner_reg <= rcnt_reg[3:0];
        if (state_reg == ST_READ && rvalid_reg)
            v_reg[rcorner_reg] <= rdata_reg;
        if (state_reg == ST_BLEND)
            v_reg[dst] <= blended;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rcnt_reg <= '0;
            bcnt_reg <= '0;
            rvalid_reg <= 1'b0;
            ov_reg <= 1'b0;
            res_reg <= '0;
            err_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rcnt_reg <= rcnt_next;
            bcnt_reg <= bcnt_next;
            rvalid_reg <= mem_re;
            if (ov_reg && !out_stall)
                ov_reg <= 1'b0;
            if (state_reg == ST_OUT && !ov_reg)
            begin
                ov_reg <= 1'b1;
                err_reg <= (cur_reg.kind == KIND_ERROR);
                res_reg <= (cur_reg.kind == KIND_ERROR) ? '0 : v_reg[0];
            end
        end
    end

    assign out_valid = ov_reg;
    assign interpolated = res_reg;
    assign index_error = err_reg;
endmodule

// ===== sv/quadrilinear_table_interpolator_top.sv =====
// quadrilinear_table_interpolator_top: 4d table interpolator top level
// depends on qti_pkg, qti_front, qti_back
//
//   channel | direction | handshake          | fields
//   in      | in        | in_valid/in_stall  | op, upper_index_0..3, fraction_0..3, entry_value
//   out     | out       | out_valid/out_stall| interpolated, index_error
//
// a write occupies the back end only while it is dequeued; a query is dequeued, then makes
// the 16 corner reads from the single-port table memory through a registered read port,
// 15 blend steps through one multiplier and a load of the output register
// an error query is dequeued and loads the output register; the 2-entry queue stalls the input
// when full; the output register holds a result while stalled and the back end waits
// reset clears control and the output registers; table entries are undefined until written
`timescale 1ns / 1ps
module quadrilinear_table_interpolator_top
    import qti_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    op,
    input  logic [AXIS_BITS-1:0]    upper_index_0,
    input  logic [AXIS_BITS-1:0]    upper_index_1,
    input  logic [AXIS_BITS-1:0]    upper_index_2,
    input  logic [AXIS_BITS-1:0]    upper_index_3,
    input  logic [FRAC_BITS-1:0]    fraction_0,
    input  logic [FRAC_BITS-1:0]    fraction_1,
    input  logic [FRAC_BITS-1:0]    fraction_2,
    input  logic [FRAC_BITS-1:0]    fraction_3,
    input  logic signed [DATA_BITS-1:0] entry_value,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [DATA_BITS-1:0] interpolated,
    output logic                    index_error
);
    logic cmd_valid, cmd_pop;
    cmd_t cmd;

    // front: classify and queue items
    qti_front u_front (
        .clk, .rst_n, .in_valid, .in_stall, .op,
        .upper_index_0, .upper_index_1, .upper_index_2, .upper_index_3,
        .fraction_0, .fraction_1, .fraction_2, .fraction_3, .entry_value,
        .cmd_valid, .cmd_pop, .cmd
    );

    // back: table writes, corner reads, blend, result register
    qti_back u_back (
        .clk, .rst_n, .cmd_valid, .cmd_pop, .cmd,
        .out_valid, .out_stall, .interpolated, .index_error
    );
endmodule

// ===== sv/qti_checker.sv =====
// qti_checker: port-level assertions for the interpolator
// depends on quadrilinear_table_interpolator_top
`timescale 1ns / 1ps
module qti_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] interpolated,
    input logic        index_error
);
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && index_error |-> interpolated == '0) else $error("error result not zero");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(interpolated)) else $error("result dropped");
    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall |=> !out_valid) else $error("result repeated");
endmodule

bind quadrilinear_table_interpolator_top qti_checker u_qti_checker (
    .clk, .rst_n, .out_valid, .out_stall, .interpolated, .index_error
);
